FILE: rtl/mks_pkg.sv
// shared constants, codes and beat types for the keep-alive supervisor
`timescale 1ns / 1ps
package mks_pkg;

	localparam int IDLE_W = 27;
	localparam int THR_W = 26;
	localparam int CMP_W = (IDLE_W > THR_W) ? IDLE_W : THR_W;

	localparam logic [15:0] KA_RESET = 16'd15;
	localparam logic [9:0] MS_PER_S = 10'd1000;
	localparam logic [THR_W-1:0] FULL_RESET = THR_W'(KA_RESET) * THR_W'(MS_PER_S);
	localparam logic [THR_W-1:0] HALF_RESET = FULL_RESET >> 1;
	localparam logic [IDLE_W-1:0] IDLE_MAX = '1;

	localparam logic [2:0] CMD_TICK = 3'd0;
	localparam logic [2:0] CMD_OPEN = 3'd1;
	localparam logic [2:0] CMD_RECV = 3'd2;
	localparam logic [2:0] CMD_SENT = 3'd3;
	localparam logic [2:0] CMD_SUBSCRIBE = 3'd4;
	localparam logic [2:0] CMD_CLOSE = 3'd5;
	localparam logic [2:0] CMD_LOST = 3'd6;
	localparam logic [2:0] CMD_UNUSED = 3'd7;

	localparam logic [2:0] ACT_NONE = 3'd0;
	localparam logic [2:0] ACT_PINGREQ = 3'd1;
	localparam logic [2:0] ACT_PINGRESP = 3'd2;
	localparam logic [2:0] ACT_DROP = 3'd3;
	localparam logic [2:0] ACT_PUBLISH = 3'd4;
	localparam logic [2:0] ACT_ACCEPTED = 3'd5;
	localparam logic [2:0] ACT_REFUSED = 3'd6;
	localparam logic [2:0] ACT_DISCONNECT = 3'd7;

	localparam logic [3:0] PT_PUBLISH = 4'd3;
	localparam logic [3:0] PT_PINGREQ = 4'd12;
	localparam logic [3:0] PT_PINGRESP = 4'd13;

	localparam logic [15:0] CONNACK_LEN = 16'd4;
	localparam logic [7:0] RC_ACCEPTED = 8'd0;

	typedef struct packed {
		logic [THR_W-1:0] full;
		logic [THR_W-1:0] half;
	} thr_t;

	typedef struct packed {
		logic [7:0]  return_code;
		logic [15:0] packet_length;
		logic [3:0]  packet_type;
		logic [2:0]  command;
	} evt_t;

	typedef struct packed {
		logic [15:0] message_id;
		logic        ping_pending;
		logic [1:0]  link_state;
		logic [2:0]  action;
	} res_t;

endpackage

FILE: rtl/mks_thresh.sv
// keep-alive register, held as full and half timeout in milliseconds
`timescale 1ns / 1ps
module mks_thresh import mks_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	output thr_t        thr
);

	logic [THR_W-1:0] full_d;
	logic [THR_W-1:0] full_q;
	logic [THR_W-1:0] half_q;

	assign full_d = THR_W'(cfg_wdata) * THR_W'(MS_PER_S);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= FULL_RESET;
			half_q <= HALF_RESET;
		end else if (cfg_we) begin
			full_q <= full_d;
			half_q <= full_d >> 1;
		end
	end

	assign thr.full = full_q;
	assign thr.half = half_q;

endmodule

FILE: rtl/mks_fsm.sv
// link state, idle counters, ping flag and message id with per-beat update
`timescale 1ns / 1ps
module mks_fsm import mks_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic fire,
	input  evt_t evt,
	input  thr_t thr,
	output res_t res
);

	typedef enum logic [1:0] {
		PH_DISCONNECTED = 2'd0,
		PH_AWAITING     = 2'd1,
		PH_CONNECTED    = 2'd2
	} phase_t;

	phase_t            phase_q, phase_d;
	logic [IDLE_W-1:0] in_q, in_d, out_q, out_d;
	logic [IDLE_W-1:0] in_inc, out_inc;
	logic              ping_q, ping_d;
	logic [15:0]       id_q, id_d, id_inc;
	logic [2:0]        act;
	logic              in_over_full, in_over_half, out_over_half;

	assign in_inc = (in_q == IDLE_MAX) ? in_q : in_q + IDLE_W'(1);
	assign out_inc = (out_q == IDLE_MAX) ? out_q : out_q + IDLE_W'(1);
	assign id_inc = id_q + 16'd1;

	assign in_over_full = CMP_W'(in_inc) > CMP_W'(thr.full);
	assign in_over_half = CMP_W'(in_inc) > CMP_W'(thr.half);
	assign out_over_half = CMP_W'(out_inc) > CMP_W'(thr.half);

	always_comb begin
		phase_d = phase_q;
		in_d = in_q;
		out_d = out_q;
		ping_d = ping_q;
		id_d = id_q;
		act = ACT_NONE;
		unique case (evt.command)
			CMD_TICK: begin
				if (phase_q == PH_AWAITING) begin
					in_d = in_inc;
					if (in_over_full) begin
						phase_d = PH_DISCONNECTED;
						act = ACT_DROP;
					end
				end else if (phase_q == PH_CONNECTED) begin
					in_d = in_inc;
					out_d = out_inc;
					if (in_over_half || out_over_half) begin
						if (ping_q) begin
							phase_d = PH_DISCONNECTED;
							act = ACT_DROP;
						end else begin
							in_d = '0;
							out_d = '0;
							ping_d = 1'b1;
							act = ACT_PINGREQ;
						end
					end
				end
			end
			CMD_OPEN: begin
				if (phase_q == PH_DISCONNECTED) begin
					phase_d = PH_AWAITING;
					in_d = '0;
					out_d = '0;
					id_d = 16'd1;
				end
			end
			CMD_RECV: begin
				if (phase_q == PH_AWAITING) begin
					if (evt.packet_length == CONNACK_LEN && evt.return_code == RC_ACCEPTED) begin
						phase_d = PH_CONNECTED;
						in_d = '0;
						ping_d = 1'b0;
						act = ACT_ACCEPTED;
					end else begin
						phase_d = PH_DISCONNECTED;
						act = ACT_REFUSED;
					end
				end else if (phase_q == PH_CONNECTED && evt.packet_length != 16'd0) begin
					in_d = '0;
					priority if (evt.packet_type == PT_PUBLISH) begin
						act = ACT_PUBLISH;
					end else if (evt.packet_type == PT_PINGREQ) begin
						act = ACT_PINGRESP;
					end else if (evt.packet_type == PT_PINGRESP) begin
						ping_d = 1'b0;
					end else begin
						act = ACT_NONE;
					end
				end
			end
			CMD_SENT: begin
				if (phase_q != PH_DISCONNECTED) begin
					out_d = '0;
				end
			end
			CMD_SUBSCRIBE: begin
				if (phase_q == PH_CONNECTED) begin
					id_d = (id_inc == 16'd0) ? 16'd1 : id_inc;
					out_d = '0;
				end
			end
			CMD_CLOSE: begin
				if (phase_q != PH_DISCONNECTED) begin
					phase_d = PH_DISCONNECTED;
					in_d = '0;
					out_d = '0;
					act = ACT_DISCONNECT;
				end
			end
			CMD_LOST: begin
				phase_d = PH_DISCONNECTED;
			end
			CMD_UNUSED: begin
				act = ACT_NONE;
			end
			default: begin
				act = ACT_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DISCONNECTED;
			in_q <= '0;
			out_q <= '0;
			ping_q <= 1'b0;
			id_q <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			in_q <= in_d;
			out_q <= out_d;
			ping_q <= ping_d;
			id_q <= id_d;
		end
	end

	assign res.action = act;
	assign res.link_state = phase_d;
	assign res.ping_pending = ping_d;
	assign res.message_id = id_d;

	a_id_nonzero_connected: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_CONNECTED |-> id_q != 16'd0)
		else $error("message id zero while connected");

	a_drop_disconnects: assert property (@(posedge clk) disable iff (!arst_n)
		fire && act == ACT_DROP |=> phase_q == PH_DISCONNECTED)
		else $error("drop did not leave link disconnected");

	a_pingreq_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && act == ACT_PINGREQ |=> ping_q && in_q == '0 && out_q == '0)
		else $error("pingreq did not arm ping and clear counters");

	a_accept_connects: assert property (@(posedge clk) disable iff (!arst_n)
		fire && act == ACT_ACCEPTED |=> phase_q == PH_CONNECTED && !ping_q)
		else $error("accepted connack did not connect");

endmodule

FILE: rtl/mqtt_keepalive_supervisor.sv
// top level: event input stage, supervisor update, result output stage
//
// channel  dir  handshake          payload
// s_       in   s_tvalid/s_tready  s_tuser command, s_tdata type/length/return code
// m_       out  m_tvalid/m_tready  m_tuser action, m_tdata state/ping/message id
// cfg_     in   cfg_we             cfg_wdata keep-alive seconds
//
// one beat per clock sustained while m_tready stays high; an input beat reaches the result beat
// through the input register, then the state update into the result register
// arst_n clears link state, counters, ping flag, message id and both valids
// a stalled result holds while the input register still takes one more beat
`timescale 1ns / 1ps
module mqtt_keepalive_supervisor import mks_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [2:0]  s_tuser,  // command
	input  logic [31:0] s_tdata,  // packet_type, packet_length, return_code
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [2:0]  m_tuser,  // action
	output logic [23:0] m_tdata   // link_state, ping_pending, message_id
);

	thr_t thr;
	evt_t evt_in;
	evt_t evt_s1;
	res_t res;
	res_t res_s2;
	logic valid_s1;
	logic valid_s2;
	logic adv;

	assign evt_in.command = s_tuser;
	assign evt_in.packet_type = s_tdata[3:0];
	assign evt_in.packet_length = s_tdata[19:4];
	assign evt_in.return_code = s_tdata[27:20];

	assign adv = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;

	mks_thresh u_thresh (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.thr       (thr)
	);

	mks_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (adv),
		.evt    (evt_s1),
		.thr    (thr),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			evt_s1 <= evt_in;
		end
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser = res_s2.action;
	assign m_tdata = {5'd0, res_s2.message_id, res_s2.ping_pending, res_s2.link_state};

endmodule
